@@ rtl/core/pam_pkg.sv @@
// Shared constants and control types for the polynomial add/multiply block.
package pam_pkg;

	localparam int MAX_TERMS    = 32;
	localparam int COEF_BITS    = 16;
	localparam int COEF_IN_BITS = 16;
	localparam int RES_BITS     = 40;
	localparam int DEG_BITS     = 6;

	typedef struct packed {
		logic a_we;
		logic b_we;
	} pam_load_t;

	typedef struct packed {
		logic valid;
		logic sum;
		logic a_ok;
		logic b_ok;
		logic first;
		logic last;
		logic fin;
	} pam_issue_t;

endpackage

@@ rtl/core/pam_ram.sv @@
// Generic single-write, registered-read RAM.
module pam_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/core/pam_datapath.sv @@
// Datapath: operand stores, multiply/add stage, accumulator and result register.
module pam_datapath #(
	parameter int MAX_TERMS = pam_pkg::MAX_TERMS,
	parameter int COEF_BITS = pam_pkg::COEF_BITS,
	localparam int IDX_W    = $clog2(MAX_TERMS),
	localparam int K_W      = $clog2(2 * MAX_TERMS)
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic signed [pam_pkg::COEF_IN_BITS-1:0] coefficient,
	input  pam_pkg::pam_load_t                     load,
	input  logic [IDX_W-1:0]                       wr_addr,
	input  pam_pkg::pam_issue_t                    issue,
	input  logic [IDX_W-1:0]                       a_idx,
	input  logic [IDX_W-1:0]                       b_idx,
	input  logic [K_W-1:0]                         deg,
	input  logic                                   trunc,
	output logic                                   pipe_busy,
	output logic                                   result_valid,
	output logic signed [pam_pkg::RES_BITS-1:0]    result_coefficient,
	output logic [pam_pkg::DEG_BITS-1:0]           degree,
	output logic                                   final_res,
	output logic                                   truncated
);

	localparam int PW    = 2 * COEF_BITS;
	localparam int ACC_W = PW + IDX_W + 1;

	logic signed [COEF_BITS-1:0] coef_ext;
	logic [COEF_BITS-1:0]        rd_a;
	logic [COEF_BITS-1:0]        rd_b;
	logic signed [COEF_BITS-1:0] a_val;
	logic signed [COEF_BITS-1:0] b_val;
	logic signed [PW-1:0]        prod_c;
	logic signed [PW-1:0]        sum_c;
	logic signed [ACC_W-1:0]     acc_next;

	pam_pkg::pam_issue_t         iss_s1;
	pam_pkg::pam_issue_t         iss_s2;
	logic [K_W-1:0]              deg_s1;
	logic [K_W-1:0]              deg_s2;
	logic signed [ACC_W-1:0]     val_s2;
	logic signed [ACC_W-1:0]     acc_q;
	logic                        res_valid_q;
	logic signed [pam_pkg::RES_BITS-1:0] res_q;
	logic [pam_pkg::DEG_BITS-1:0] deg_q;
	logic                        fin_q;
	logic                        trunc_q;

	generate
		if (COEF_BITS <= pam_pkg::COEF_IN_BITS) begin : g_narrow
			assign coef_ext = coefficient[COEF_BITS-1:0];
		end else begin : g_wide
			assign coef_ext = COEF_BITS'($unsigned(coefficient));
		end
	endgenerate

	pam_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TERMS)) u_first_ram (
		.clk   (clk),
		.we    (load.a_we),
		.waddr (wr_addr),
		.wdata (coef_ext),
		.re    (issue.valid),
		.raddr (a_idx),
		.rdata (rd_a)
	);

	pam_ram #(.WIDTH(COEF_BITS), .DEPTH(MAX_TERMS)) u_second_ram (
		.clk   (clk),
		.we    (load.b_we),
		.waddr (wr_addr),
		.wdata (coef_ext),
		.re    (issue.valid),
		.raddr (b_idx),
		.rdata (rd_b)
	);

	assign a_val    = iss_s1.a_ok ? $signed(rd_a) : '0;
	assign b_val    = iss_s1.b_ok ? $signed(rd_b) : '0;
	assign prod_c   = a_val * b_val;
	assign sum_c    = PW'(a_val) + PW'(b_val);
	assign acc_next = (iss_s2.first ? '0 : acc_q) + val_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_s1      <= '0;
			iss_s2      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			iss_s1      <= issue;
			iss_s2      <= iss_s1;
			res_valid_q <= iss_s2.valid & iss_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		deg_s1 <= deg;
		deg_s2 <= deg_s1;
		val_s2 <= ACC_W'(iss_s1.sum ? sum_c : prod_c);
		if (iss_s2.valid) begin
			acc_q <= acc_next;
		end
		if (iss_s2.valid & iss_s2.last) begin
			res_q   <= pam_pkg::RES_BITS'(acc_next);
			deg_q   <= pam_pkg::DEG_BITS'(deg_s2);
			fin_q   <= iss_s2.fin;
			trunc_q <= trunc;
		end
	end

	assign pipe_busy          = iss_s1.valid | iss_s2.valid;
	assign result_valid       = res_valid_q;
	assign result_coefficient = res_q;
	assign degree             = deg_q;
	assign final_res          = fin_q;
	assign truncated          = trunc_q;

endmodule

@@ rtl/core/pam_ctrl.sv @@
// Controller: operand counts, operation register and the term sequencer.
module pam_ctrl #(
	parameter int MAX_TERMS = pam_pkg::MAX_TERMS,
	localparam int IDX_W    = $clog2(MAX_TERMS),
	localparam int CNT_W    = $clog2(MAX_TERMS + 1),
	localparam int K_W      = $clog2(2 * MAX_TERMS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                action,
	input  logic                last,
	input  logic                cfg_valid,
	input  logic                cfg_data,
	output logic                cfg_ready,
	output logic                busy,
	output pam_pkg::pam_load_t  load,
	output logic [IDX_W-1:0]    wr_addr,
	output pam_pkg::pam_issue_t issue,
	output logic [IDX_W-1:0]    a_idx,
	output logic [IDX_W-1:0]    b_idx,
	output logic [K_W-1:0]      deg,
	output logic                trunc,
	input  logic                pipe_busy
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SETUP,
		ST_CALC,
		ST_DRAIN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] fcnt_q;
	logic [CNT_W-1:0] scnt_q;
	logic             ovf_q;
	logic             op_q;
	logic [K_W-1:0]   n_q;
	logic [K_W-1:0]   m_q;
	logic [K_W-1:0]   len_q;
	logic [K_W-1:0]   k_q;
	logic [IDX_W-1:0] i_q;

	logic             accept;
	logic             f_room;
	logic             s_room;
	logic [K_W-1:0]   n_c;
	logic [K_W-1:0]   m_c;
	logic [K_W-1:0]   i_ext;
	logic [K_W-1:0]   j_c;
	logic [K_W-1:0]   b_full;
	logic [K_W-1:0]   hi_c;
	logic [K_W-1:0]   k_nxt;
	logic [K_W-1:0]   lo_nxt;
	logic             sum_mode;
	logic             term_first;
	logic             term_last;
	logic             term_fin;

	function automatic logic [K_W-1:0] lo_of(input logic [K_W-1:0] k, input logic [K_W-1:0] m);
		return (k >= m) ? (k - m + K_W'(1)) : '0;
	endfunction

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = ~busy;
	assign accept    = start & ~busy;
	assign f_room    = (fcnt_q < CNT_W'(MAX_TERMS));
	assign s_room    = (scnt_q < CNT_W'(MAX_TERMS));
	assign load.a_we = accept & ~action & f_room;
	assign load.b_we = accept & action & s_room;
	assign wr_addr   = action ? scnt_q[IDX_W-1:0] : fcnt_q[IDX_W-1:0];

	assign n_c = (fcnt_q == '0) ? K_W'(1) : K_W'(fcnt_q);
	assign m_c = (scnt_q == '0) ? K_W'(1) : K_W'(scnt_q);

	assign sum_mode   = ~op_q;
	assign i_ext      = K_W'(i_q);
	assign j_c        = k_q - i_ext;
	assign b_full     = sum_mode ? k_q : j_c;
	assign hi_c       = (k_q < n_q) ? k_q : (n_q - K_W'(1));
	assign k_nxt      = k_q + K_W'(1);
	assign lo_nxt     = lo_of(k_nxt, m_q);
	assign term_first = sum_mode | (i_ext == lo_of(k_q, m_q));
	assign term_last  = sum_mode | (i_ext == hi_c);
	assign term_fin   = (k_q == len_q - K_W'(1));

	assign issue.valid = (state_q == ST_CALC);
	assign issue.sum   = sum_mode;
	assign issue.a_ok  = (i_ext < K_W'(fcnt_q));
	assign issue.b_ok  = (b_full < K_W'(scnt_q));
	assign issue.first = term_first;
	assign issue.last  = term_last;
	assign issue.fin   = term_fin;
	assign a_idx       = i_q;
	assign b_idx       = b_full[IDX_W-1:0];
	assign deg         = k_q;
	assign trunc       = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fcnt_q  <= '0;
			scnt_q  <= '0;
			ovf_q   <= 1'b0;
			op_q    <= 1'b1;
			n_q     <= '0;
			m_q     <= '0;
			len_q   <= '0;
			k_q     <= '0;
			i_q     <= '0;
		end else begin
			if (cfg_valid & cfg_ready) begin
				op_q <= cfg_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!action) begin
							if (f_room) begin
								fcnt_q <= fcnt_q + CNT_W'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end else begin
							if (s_room) begin
								scnt_q <= scnt_q + CNT_W'(1);
							end else begin
								ovf_q <= 1'b1;
							end
							if (last) begin
								state_q <= ST_SETUP;
							end
						end
					end
				end
				ST_SETUP: begin
					n_q   <= n_c;
					m_q   <= m_c;
					len_q <= op_q ? (n_c + m_c - K_W'(1)) : ((n_c > m_c) ? n_c : m_c);
					k_q   <= '0;
					i_q   <= '0;
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (term_last) begin
						if (term_fin) begin
							state_q <= ST_DRAIN;
						end else begin
							k_q <= k_nxt;
							i_q <= sum_mode ? k_nxt[IDX_W-1:0] : lo_nxt[IDX_W-1:0];
						end
					end else begin
						i_q <= i_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (!pipe_busy) begin
						fcnt_q  <= '0;
						scnt_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ rtl/core/polynomial_add_multiply.sv @@
// Top level of the polynomial add/multiply block.
// Busy stays low during and between coefficient loads. The item
// that carries the second operand's last mark starts emission: busy rises and
// results come out lowest degree first, each for one cycle under result_valid.
// The receiver cannot stall, so it must take every strobed result. A single
// multiply-accumulate unit reads both operand stores once per cycle. Write
// operation only while busy is low.
module polynomial_add_multiply #(
	parameter int MAX_TERMS = pam_pkg::MAX_TERMS,
	parameter int COEF_BITS = pam_pkg::COEF_BITS
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    start,
	output logic                                    busy,
	input  logic                                    action,
	input  logic signed [pam_pkg::COEF_IN_BITS-1:0] coefficient,
	input  logic                                    last,
	input  logic                                    cfg_valid,
	output logic                                    cfg_ready,
	input  logic                                    cfg_data,
	output logic                                    result_valid,
	output logic signed [pam_pkg::RES_BITS-1:0]     result_coefficient,
	output logic [pam_pkg::DEG_BITS-1:0]            degree,
	output logic                                    final_res,
	output logic                                    truncated
);

	localparam int IDX_W = $clog2(MAX_TERMS);
	localparam int K_W   = $clog2(2 * MAX_TERMS);

	pam_pkg::pam_load_t  load;
	pam_pkg::pam_issue_t issue;
	logic [IDX_W-1:0]    wr_addr;
	logic [IDX_W-1:0]    a_idx;
	logic [IDX_W-1:0]    b_idx;
	logic [K_W-1:0]      deg;
	logic                trunc;
	logic                pipe_busy;

	pam_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.action    (action),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.busy      (busy),
		.load      (load),
		.wr_addr   (wr_addr),
		.issue     (issue),
		.a_idx     (a_idx),
		.b_idx     (b_idx),
		.deg       (deg),
		.trunc     (trunc),
		.pipe_busy (pipe_busy)
	);

	pam_datapath #(.MAX_TERMS(MAX_TERMS), .COEF_BITS(COEF_BITS)) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.coefficient        (coefficient),
		.load               (load),
		.wr_addr            (wr_addr),
		.issue              (issue),
		.a_idx              (a_idx),
		.b_idx              (b_idx),
		.deg                (deg),
		.trunc              (trunc),
		.pipe_busy          (pipe_busy),
		.result_valid       (result_valid),
		.result_coefficient (result_coefficient),
		.degree             (degree),
		.final_res          (final_res),
		.truncated          (truncated)
	);

endmodule
